FILE: rtl/core/spi_pkg.sv
// Package for the segment/plane intersection core: status codes, register
// indexes, widths and shared types. No dependencies.
package spi_pkg;

   localparam int CoordW = 32;
   localparam int NormW  = 16;
   localparam int DistW  = 51;   // |f| < 2^49, plus headroom and sign
   localparam int MagW   = 50;   // magnitude of f1 and of f1 - f2
   localparam int DeltaW = 33;   // magnitude of p2 - p1
   localparam int ProdW  = DeltaW + MagW;
   localparam int QuotW  = 33;   // quotient is at most |d| < 2^33

   typedef enum logic [1:0] {
      STATUS_HIT      = 2'd0,
      STATUS_NO_SPAN  = 2'd1,
      STATUS_PARALLEL = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      REG_NORMAL_X = 2'd0,
      REG_NORMAL_Y = 2'd1,
      REG_NORMAL_Z = 2'd2,
      REG_OFFSET   = 2'd3
   } reg_index_type;

   // Per-axis divider input word
   typedef struct packed {
      logic              neg;
      logic [CoordW-1:0] base;
      logic [ProdW-1:0]  num;
   } div_in_type;

endpackage

FILE: rtl/core/spi_div_pipe.sv
// Pipelined restoring divider, one quotient bit per stage.
// Depends on spi_pkg. Accepts one word per cycle.
module spi_div_pipe (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_valid,
   input  logic [spi_pkg::MagW-1:0]       den,
   input  spi_pkg::div_in_type [2:0]      in_word,
   input  spi_pkg::status_type            in_status,
   output logic                           out_valid,
   output spi_pkg::status_type            out_status,
   output logic [3*spi_pkg::CoordW-1:0]   out_hit
);
   localparam int N  = spi_pkg::QuotW;
   localparam int PW = spi_pkg::ProdW;
   localparam int MW = spi_pkg::MagW;
   localparam int CW = spi_pkg::CoordW;

   // stage s holds: remainder (MW+1 bits), remaining dividend bits, quotient
   logic [N:0]                 vld_ff;
   spi_pkg::status_type        st_ff  [N+1];
   logic [MW-1:0]              den_ff [N+1];
   logic [MW:0]                rem_ff [N+1][3];
   logic [PW-1:0]              num_ff [N+1][3];
   logic [N-1:0]               q_ff   [N+1][3];
   logic                       neg_ff [N+1][3];
   logic [CW-1:0]              base_ff[N+1][3];

   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else vld_ff <= {vld_ff[N-1:0], in_valid};
   end

   // Stage 0: the upper bits of the product enter as initial remainder.
   // Quotient fits N bits, so the top PW-N bits are below den.
   // Stages 1..N: one trial subtract per stage.
   always_ff @(posedge clock) begin
      logic [MW:0] trial;
      st_ff[0]  <= in_status;
      den_ff[0] <= den;
      for (int a = 0; a < 3; a++) begin
         rem_ff[0][a]  <= {1'b0, in_word[a].num[PW-1 -: MW]};
         num_ff[0][a]  <= in_word[a].num << MW;
         q_ff[0][a]    <= '0;
         neg_ff[0][a]  <= in_word[a].neg;
         base_ff[0][a] <= in_word[a].base;
      end
      for (int s = 0; s < N; s++) begin
         st_ff[s+1]  <= st_ff[s];
         den_ff[s+1] <= den_ff[s];
         for (int a = 0; a < 3; a++) begin
            trial = {rem_ff[s][a][MW-1:0], num_ff[s][a][PW-1]};
            if (trial >= {1'b0, den_ff[s]}) begin
               rem_ff[s+1][a] <= trial - {1'b0, den_ff[s]};
               q_ff[s+1][a]   <= {q_ff[s][a][N-2:0], 1'b1};
            end else begin
               rem_ff[s+1][a] <= trial;
               q_ff[s+1][a]   <= {q_ff[s][a][N-2:0], 1'b0};
            end
            num_ff[s+1][a]  <= num_ff[s][a] << 1;
            neg_ff[s+1][a]  <= neg_ff[s][a];
            base_ff[s+1][a] <= base_ff[s][a];
         end
      end
   end

   // Apply signed offset to P1; zero hit fields unless a hit
   always_comb begin
      logic [CW-1:0] qv;
      out_valid  = vld_ff[N];
      out_status = st_ff[N];
      out_hit    = '0;
      for (int a = 0; a < 3; a++) begin
         qv = q_ff[N][a][CW-1:0];
         if (st_ff[N] == spi_pkg::STATUS_HIT)
            out_hit[a*CW +: CW] = neg_ff[N][a] ? base_ff[N][a] - qv
                                               : base_ff[N][a] + qv;
      end
   end
endmodule

FILE: rtl/core/segment_plane_intersect_core.sv
// Top level of the segment/plane intersection core.
// Depends on spi_pkg and spi_div_pipe.
//
// Usage:
//   Configuration: csr_valid/csr_ready write channel, csr_index selects
//   normal_x, normal_y, normal_z or plane_offset; csr_ready is always high.
//   Write only while no word is in flight.
//   Request: a word of two Q16.16 endpoints is taken at a clock edge with
//   start high and busy low. busy is tied low: one word per cycle.
//   Response: rsp_strobe marks one cycle carrying rsp_status and the hit
//   point. The receiver cannot stall; every word is delivered.
//   Pipeline: normal*coordinate products, then the distances f1 and f2,
//   then the span test and magnitudes, then the three |d| * |f1| products,
//   then the divider, one quotient bit per stage.
//   Throughput: one word per cycle, set by the fully pipelined divider.
//   Reset: synchronous, clears all valid bits and loads the reset plane
//   (normal 0,0,1.0 and offset 0).
module segment_plane_intersect_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [31:0] req_start_x,
   input  logic signed [31:0] req_start_y,
   input  logic signed [31:0] req_start_z,
   input  logic signed [31:0] req_end_x,
   input  logic signed [31:0] req_end_y,
   input  logic signed [31:0] req_end_z,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [31:0]        csr_data,
   output logic               rsp_strobe,
   output logic [1:0]         rsp_status,
   output logic signed [31:0] rsp_hit_x,
   output logic signed [31:0] rsp_hit_y,
   output logic signed [31:0] rsp_hit_z
);
   localparam int DW = spi_pkg::DistW;
   localparam int MW = spi_pkg::MagW;
   localparam int EW = spi_pkg::DeltaW;
   localparam int PW = spi_pkg::ProdW;
   localparam int CW = spi_pkg::CoordW;

   logic signed [15:0] nx_ff, ny_ff, nz_ff;
   logic signed [31:0] off_ff;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         nx_ff  <= '0;
         ny_ff  <= '0;
         nz_ff  <= 16'sd16384;
         off_ff <= '0;
      end else if (csr_valid) begin
         unique case (spi_pkg::reg_index_type'(csr_index))
            spi_pkg::REG_NORMAL_X: nx_ff  <= csr_data[15:0];
            spi_pkg::REG_NORMAL_Y: ny_ff  <= csr_data[15:0];
            spi_pkg::REG_NORMAL_Z: nz_ff  <= csr_data[15:0];
            spi_pkg::REG_OFFSET:   off_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // Stage 1: six normal*coordinate products, endpoint deltas
   logic [3:0] v_ff;
   logic signed [47:0] pr1_ff [3], pr2_ff [3];
   logic signed [CW-1:0] p1_1_ff [3];
   logic signed [EW-1:0] d_1_ff [3];
   logic signed [DW-1:0] offs_1_ff;
   logic signed [CW-1:0] s_in [3], e_in [3];
   logic signed [15:0]   n_in [3];

   assign s_in = '{req_start_x, req_start_y, req_start_z};
   assign e_in = '{req_end_x, req_end_y, req_end_z};
   assign n_in = '{nx_ff, ny_ff, nz_ff};

   always_ff @(posedge clock) begin
      if (reset) v_ff <= '0;
      else v_ff <= {v_ff[2:0], start & ~busy};
   end

   always_ff @(posedge clock) begin
      for (int a = 0; a < 3; a++) begin
         pr1_ff[a]  <= n_in[a] * s_in[a];
         pr2_ff[a]  <= n_in[a] * e_in[a];
         p1_1_ff[a] <= s_in[a];
         d_1_ff[a]  <= EW'(e_in[a]) - EW'(s_in[a]);
      end
      offs_1_ff <= DW'(off_ff) <<< 14;
   end

   // Stage 2: distances f1, f2
   logic signed [DW-1:0] f1_ff, f2_ff;
   logic signed [CW-1:0] p1_2_ff [3];
   logic signed [EW-1:0] d_2_ff [3];

   always_ff @(posedge clock) begin
      f1_ff <= DW'(pr1_ff[0]) + DW'(pr1_ff[1]) + DW'(pr1_ff[2]) + offs_1_ff;
      f2_ff <= DW'(pr2_ff[0]) + DW'(pr2_ff[1]) + DW'(pr2_ff[2]) + offs_1_ff;
      p1_2_ff <= p1_1_ff;
      d_2_ff  <= d_1_ff;
   end

   // Stage 3: span test, magnitudes of f1 and f1 - f2
   logic signed [DW-1:0] den_w;
   spi_pkg::status_type  st_3_ff;
   logic [MW-1:0]        af1_ff, aden_ff;
   logic signed [CW-1:0] p1_3_ff [3];
   logic signed [EW-1:0] d_3_ff [3];

   assign den_w = f1_ff - f2_ff;

   always_ff @(posedge clock) begin
      if ((f1_ff >= 0 && f2_ff >= 0) || (f1_ff <= 0 && f2_ff <= 0))
         st_3_ff <= spi_pkg::STATUS_NO_SPAN;
      else if (den_w == 0)
         st_3_ff <= spi_pkg::STATUS_PARALLEL;
      else
         st_3_ff <= spi_pkg::STATUS_HIT;
      af1_ff  <= MW'(f1_ff < 0 ? -f1_ff : f1_ff);
      aden_ff <= MW'(den_w < 0 ? -den_w : den_w);
      p1_3_ff <= p1_2_ff;
      d_3_ff  <= d_2_ff;
   end

   // Stage 4: |d| * |f1|, 33 x 50 split into 33 x 25 halves
   spi_pkg::div_in_type [2:0] dw_ff;
   spi_pkg::status_type       st_4_ff;
   logic [MW-1:0]             aden_4_ff;
   logic [EW-1:0]             ad [3];

   always_comb begin
      for (int a = 0; a < 3; a++)
         ad[a] = d_3_ff[a] < 0 ? EW'(-d_3_ff[a]) : EW'(d_3_ff[a]);
   end

   always_ff @(posedge clock) begin
      for (int a = 0; a < 3; a++) begin
         dw_ff[a].num  <= (PW'(ad[a]) * PW'(af1_ff[MW-1:25]) << 25)
                        + PW'(ad[a]) * PW'(af1_ff[24:0]);
         dw_ff[a].neg  <= d_3_ff[a] < 0;
         dw_ff[a].base <= p1_3_ff[a];
      end
      st_4_ff   <= st_3_ff;
      aden_4_ff <= (st_3_ff == spi_pkg::STATUS_HIT) ? aden_ff : MW'(1);
   end

   logic [3*CW-1:0]     hit_w;
   spi_pkg::status_type st_o;

   spi_div_pipe u_div (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (v_ff[3]),
      .den        (aden_4_ff),
      .in_word    (dw_ff),
      .in_status  (st_4_ff),
      .out_valid  (rsp_strobe),
      .out_status (st_o),
      .out_hit    (hit_w)
   );

   assign rsp_status = st_o;
   assign rsp_hit_x  = hit_w[CW-1:0];
   assign rsp_hit_y  = hit_w[2*CW-1:CW];
   assign rsp_hit_z  = hit_w[3*CW-1:2*CW];

   // Parallel cannot follow a spanning pair
   a_no_parallel: assert property (@(posedge clock) disable iff (reset)
      v_ff[2] |-> st_3_ff != spi_pkg::STATUS_PARALLEL)
      else $error("parallel status reached");
   // Misses carry a zero point
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_status != spi_pkg::STATUS_HIT) |->
         (rsp_hit_x == 0 && rsp_hit_y == 0 && rsp_hit_z == 0))
      else $error("nonzero point on miss");
   // Divider is fed a nonzero divisor
   a_den_nz: assert property (@(posedge clock) disable iff (reset)
      v_ff[3] |-> aden_4_ff != 0)
      else $error("zero divisor");
endmodule

FILE: dv/spi_checker.sv
// Scoreboard for the segment/plane intersection core: tracks plane register
// writes, predicts one hit word per accepted request and compares responses.
// Depends on spi_pkg.
`timescale 1ns / 1ps

module spi_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               busy,
   input  logic signed [31:0] req_start_x,
   input  logic signed [31:0] req_start_y,
   input  logic signed [31:0] req_start_z,
   input  logic signed [31:0] req_end_x,
   input  logic signed [31:0] req_end_y,
   input  logic signed [31:0] req_end_z,
   input  logic               csr_valid,
   input  logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [31:0]        csr_data,
   input  logic               rsp_strobe,
   input  logic [1:0]         rsp_status,
   input  logic signed [31:0] rsp_hit_x,
   input  logic signed [31:0] rsp_hit_y,
   input  logic signed [31:0] rsp_hit_z,
   output int                 pending,
   output int                 failures
);

   typedef struct {
      spi_pkg::status_type status;
      logic signed [31:0]  hx;
      logic signed [31:0]  hy;
      logic signed [31:0]  hz;
   } hit_word_type;

   // plane copy
   logic signed [15:0] plane_nx, plane_ny, plane_nz;
   logic signed [31:0] plane_off;
   hit_word_type       hits_due[$];

   // signed distance in Q.30, exact
   function automatic longint plane_dist(logic signed [31:0] px, logic signed [31:0] py,
                                         logic signed [31:0] pz);
      return longint'(plane_nx) * longint'(px) + longint'(plane_ny) * longint'(py)
           + longint'(plane_nz) * longint'(pz) + longint'(plane_off) * 64'sd16384;
   endfunction

   // point on segment at t = f1/(f1-f2), truncated toward the start point
   function automatic logic signed [31:0] lerp_axis(logic signed [31:0] p1,
                                                    logic signed [31:0] p2,
                                                    longint af1, longint aden);
      longint       d;
      logic [127:0] prod, q;
      longint       h;
      d    = longint'(p2) - longint'(p1);
      prod = 128'(d < 0 ? -d : d) * 128'(af1);
      q    = prod / 128'(aden);
      h    = (d < 0) ? longint'(p1) - longint'(q[63:0]) : longint'(p1) + longint'(q[63:0]);
      return h[31:0];
   endfunction

   function automatic hit_word_type predict_hit();
      hit_word_type w;
      longint       f1, f2, den;
      w = '{spi_pkg::STATUS_NO_SPAN, 32'sd0, 32'sd0, 32'sd0};
      f1 = plane_dist(req_start_x, req_start_y, req_start_z);
      f2 = plane_dist(req_end_x, req_end_y, req_end_z);
      if ((f1 >= 0 && f2 >= 0) || (f1 <= 0 && f2 <= 0)) return w;
      den = f1 - f2;
      if (den == 0) begin
         w.status = spi_pkg::STATUS_PARALLEL;
         return w;
      end
      if (f1 < 0) f1 = -f1;
      if (den < 0) den = -den;
      w.status = spi_pkg::STATUS_HIT;
      w.hx = lerp_axis(req_start_x, req_end_x, f1, den);
      w.hy = lerp_axis(req_start_y, req_end_y, f1, den);
      w.hz = lerp_axis(req_start_z, req_end_z, f1, den);
      return w;
   endfunction

   assign pending = hits_due.size();

   always @(posedge clock) begin
      hit_word_type exp_w;
      if (reset) begin
         plane_nx  <= 16'sd0;
         plane_ny  <= 16'sd0;
         plane_nz  <= 16'sd16384;
         plane_off <= 32'sd0;
         hits_due.delete();
         failures  <= 0;
      end else begin
         // response compare, then new request, then register write
         if (rsp_strobe) begin
            if (hits_due.size() == 0) begin
               $display("%0t: unexpected response status %0d hit %0d %0d %0d", $time,
                        rsp_status, rsp_hit_x, rsp_hit_y, rsp_hit_z);
               failures <= failures + 1;
            end else begin
               exp_w = hits_due.pop_front();
               if (rsp_status !== exp_w.status || rsp_hit_x !== exp_w.hx ||
                   rsp_hit_y !== exp_w.hy || rsp_hit_z !== exp_w.hz) begin
                  $display("%0t: mismatch expected status %0d hit %0d %0d %0d, %s",
                           $time, exp_w.status, exp_w.hx, exp_w.hy, exp_w.hz,
                           $sformatf("got %0d %0d %0d %0d", rsp_status, rsp_hit_x,
                                     rsp_hit_y, rsp_hit_z));
                  failures <= failures + 1;
               end
            end
         end
         if (start && !busy) hits_due.push_back(predict_hit());
         if (csr_valid && csr_ready) begin
            case (spi_pkg::reg_index_type'(csr_index))
               spi_pkg::REG_NORMAL_X: plane_nx  <= csr_data[15:0];
               spi_pkg::REG_NORMAL_Y: plane_ny  <= csr_data[15:0];
               spi_pkg::REG_NORMAL_Z: plane_nz  <= csr_data[15:0];
               spi_pkg::REG_OFFSET:   plane_off <= csr_data;
               default: ;
            endcase
         end
      end
   end

endmodule

FILE: dv/tb_top.sv
// Testbench top for segment_plane_intersect_core: drives plane settings and
// segment words, instantiates spi_checker beside the core and gives the verdict.
// Depends on spi_pkg, spi_checker and the core RTL.
`timescale 1ns / 1ps

module tb_top;

   localparam int CycleLimit = 300000;
   localparam int Latency    = 38;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic signed [31:0] req_start_x = '0, req_start_y = '0, req_start_z = '0;
   logic signed [31:0] req_end_x = '0, req_end_y = '0, req_end_z = '0;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [1:0]         csr_index = '0;
   logic [31:0]        csr_data = '0;
   logic               rsp_strobe;
   logic [1:0]         rsp_status;
   logic signed [31:0] rsp_hit_x, rsp_hit_y, rsp_hit_z;
   int                 pending, failures;
   int                 cycle_count = 0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   segment_plane_intersect_core dut (.*);
   spi_checker u_checker (.*);

   // run watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   task automatic write_plane_reg(spi_pkg::reg_index_type idx, logic [31:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // registers change only with nothing in flight
   task automatic set_plane(logic [15:0] nx, logic [15:0] ny, logic [15:0] nz,
                            logic [31:0] off);
      start <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (Latency + 2) @(negedge clock);
      write_plane_reg(spi_pkg::REG_NORMAL_X,
                      {16'(~nx), nx} ^ 32'hFFFF_0000 ^ {16'(~nx), 16'h0});
      write_plane_reg(spi_pkg::REG_NORMAL_Y, {16'($urandom_range(0, 16'hFFFF)), ny});
      write_plane_reg(spi_pkg::REG_NORMAL_Z, {16'($urandom_range(0, 16'hFFFF)), nz});
      write_plane_reg(spi_pkg::REG_OFFSET, off);
   endtask

   // mostly back-to-back, many short gaps, a few long
   task automatic send_segment(logic [31:0] sx, logic [31:0] sy, logic [31:0] sz,
                               logic [31:0] ex, logic [31:0] ey, logic [31:0] ez);
      int gap;
      int pick;
      start       <= 1'b1;
      req_start_x <= sx;
      req_start_y <= sy;
      req_start_z <= sz;
      req_end_x   <= ex;
      req_end_y   <= ey;
      req_end_z   <= ez;
      do @(posedge clock); while (busy);
      @(negedge clock);
      pick = $urandom_range(0, 99);
      gap  = (pick < 55) ? 0 : (pick < 93) ? $urandom_range(1, 3) : $urandom_range(10, 60);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   function automatic logic [31:0] rand_coord();
      int pick;
      pick = $urandom_range(0, 9);
      case (pick)
         0, 1, 2, 3: return $urandom;
         4, 5, 6:    return 32'($signed($urandom_range(0, 2000000)) - 1000000);
         7:          return 32'($signed($urandom_range(0, 200)) - 100);
         8:          return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
         default:    return 32'($signed($urandom_range(0, 131072)) - 65536) <<< 8;
      endcase
   endfunction

   function automatic logic [15:0] rand_normal();
      case ($urandom_range(0, 4))
         0:       return 16'h8000;
         1:       return 16'h7FFF;
         2:       return 16'($signed($urandom_range(0, 32768)) - 16384);
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic random_segments(int count);
      logic [31:0] sx, sy, sz;
      repeat (count) begin
         sx = rand_coord();
         sy = rand_coord();
         sz = rand_coord();
         // a third of segments end near the start point in x and y, with z inverted
         if ($urandom_range(0, 2) == 0)
            send_segment(sx, sy, sz, sx ^ 32'($urandom_range(0, 4095)),
                         sy + 32'($signed($urandom_range(0, 8191)) - 4096), ~sz);
         else
            send_segment(sx, sy, sz, rand_coord(), rand_coord(), rand_coord());
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed, reset plane z = 0
      send_segment(32'h0001_0000, 32'h0002_0000, 32'hFFFF_0000, 32'h0003_0000, 32'h0,
                   32'h0001_0000);
      send_segment(32'h0, 32'h0, 32'h0, 32'h1, 32'h1, 32'h1);            // start on plane
      send_segment(32'h5, 32'h5, 32'h0001_0000, 32'h7, 32'h7, 32'h0);   // end on plane
      send_segment(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                   32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
      send_segment(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                   32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
      send_segment(32'h0, 32'h0, 32'h0000_0001, 32'h0, 32'h0, 32'hFFFF_FFFF);
      send_segment(32'h1234_5678, 32'h0, 32'h0001_0000, 32'h1234_5678, 32'h0, 32'h0002_0000);
      send_segment(32'h0, 32'h0, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);

      // zero normal: never spans
      set_plane(16'h0, 16'h0, 16'h0, 32'h0001_0000);
      send_segment(32'h8000_0000, 32'h0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h7FFF_FFFF);
      random_segments(40);

      // most negative extremes
      set_plane(16'h8000, 16'h8000, 16'h8000, 32'h8000_0000);
      send_segment(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                   32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_segment(32'h0, 32'h0, 32'h0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      random_segments(110);

      // most positive extremes
      set_plane(16'h7FFF, 16'h7FFF, 16'h7FFF, 32'h7FFF_FFFF);
      send_segment(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                   32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_segment(32'h7FFF_FFFF, 32'h0, 32'h8000_0000, 32'h8000_0000, 32'h0, 32'h7FFF_FFFF);
      random_segments(110);

      // tilted plane through the origin
      set_plane(16'h2D41, 16'hD2BF, 16'h0, 32'h0);
      random_segments(130);

      // random planes
      repeat (3) begin
         set_plane(rand_normal(), rand_normal(), rand_normal(),
                   $urandom_range(0, 3) == 0 ? $urandom : 32'(rand_coord() >>> 4));
         random_segments(90);
      end

      start <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (Latency + 10) @(posedge clock);
      if (failures == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

FILE: segment_plane_intersect_core.f
rtl/core/spi_pkg.sv
rtl/core/spi_div_pipe.sv
rtl/core/segment_plane_intersect_core.sv
dv/spi_checker.sv
dv/tb_top.sv
